// ----- rtl/core/ppr_pkg.sv -----
// ----------------------------------------------------------------------------
// Pixel prediction residual package
// Shared constants, register map and the per-channel predictor function.
// ----------------------------------------------------------------------------
package ppr_pkg;

  // Size the row store
  localparam int unsigned PprMaxImageWidth = 1024;

  // Register map (register index = byte address / 4)
  localparam int unsigned PprAddrWidth = 3;
  localparam int unsigned PprDataWidth = 32;
  localparam logic        RegPredictorMode = 1'b0;
  localparam logic        RegImageWidth    = 1'b1;

  // Register widths and reset values
  localparam int unsigned ModeWidth      = 3;
  localparam int unsigned ImgWidthWidth  = 11;
  localparam logic [ModeWidth-1:0]     ModeReset     = 3'd7;
  localparam logic [ImgWidthWidth-1:0] ImgWidthReset = 11'd640;

  // Predictor codes
  localparam logic [ModeWidth-1:0] ModeWest     = 3'd0;
  localparam logic [ModeWidth-1:0] ModeNorth    = 3'd1;
  localparam logic [ModeWidth-1:0] ModeNorthWest = 3'd2;
  localparam logic [ModeWidth-1:0] ModePlane    = 3'd3;
  localparam logic [ModeWidth-1:0] ModeNorthAdj = 3'd4;
  localparam logic [ModeWidth-1:0] ModeWestAdj  = 3'd5;
  localparam logic [ModeWidth-1:0] ModeAverage  = 3'd6;
  localparam logic [ModeWidth-1:0] ModeMedian   = 3'd7;

  typedef logic [7:0] chan_t;

  // Build one channel prediction from west, north and northwest samples
  function automatic chan_t ppr_predict(logic [ModeWidth-1:0] mode,
                                        chan_t w, chan_t n, chan_t nw);
    logic signed [9:0] sw;
    logic signed [9:0] sn;
    logic signed [9:0] snw;
    logic signed [9:0] d_wn;
    logic signed [9:0] d_nn;
    logic signed [9:0] h_wn;
    logic signed [9:0] h_nn;
    logic signed [9:0] p;
    logic [8:0]        sum;
    chan_t             lo;
    chan_t             hi;
    sw   = $signed({2'b00, w});
    sn   = $signed({2'b00, n});
    snw  = $signed({2'b00, nw});
    d_wn = sw - snw;
    d_nn = sn - snw;
    // Halve toward zero: bias negative values by one before the shift
    h_wn = d_wn + $signed({9'b0, d_wn[9]});
    h_wn = h_wn >>> 1;
    h_nn = d_nn + $signed({9'b0, d_nn[9]});
    h_nn = h_nn >>> 1;
    sum  = {1'b0, n} + {1'b0, w};
    lo   = (n < w) ? n : w;
    hi   = (n < w) ? w : n;
    case (mode)
      ModeWest:      p = sw;
      ModeNorth:     p = sn;
      ModeNorthWest: p = snw;
      ModePlane:     p = sn + sw - snw;
      ModeNorthAdj:  p = sn + h_wn;
      ModeWestAdj:   p = sw + h_nn;
      ModeAverage:   p = $signed({2'b00, sum[8:1]});
      default: begin
        // Median edge detector
        if (nw >= hi) begin
          p = $signed({2'b00, lo});
        end else if (nw <= lo) begin
          p = $signed({2'b00, hi});
        end else begin
          p = sn + sw - snw;
        end
      end
    endcase
    return p[7:0];
  endfunction

endpackage

// ----- rtl/core/pixel_prediction_residual_top.sv -----
// ----------------------------------------------------------------------------
// Pixel prediction residual top level
// Per-channel prediction residuals of a raster BGR pixel stream.
// ----------------------------------------------------------------------------
// One pixel word is taken every clock cycle while the output side keeps
// up; its result goes through stage one, then the output register. The
// row store is a single-port synchronous RAM read and written at the same
// edge that accepts a pixel (old data is read first), so one store access
// per pixel sets the rate of one pixel per clock. The pipeline is two
// registers deep: the row store read register with the pixel beside it,
// then the output register. Raise first_of_frame_i on the top-left pixel of
// each image; without it the stream continues from the tracked position.
// The row store needs no clearing after reset. Write configuration only
// while no pixel is in flight.
module pixel_prediction_residual_top #(
  parameter int unsigned MAX_IMAGE_WIDTH = ppr_pkg::PprMaxImageWidth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ppr_pkg::PprAddrWidth-1:0]  paddr,
  input  logic [ppr_pkg::PprDataWidth-1:0]  pwdata,
  output logic [ppr_pkg::PprDataWidth-1:0]  prdata,
  output logic                              pready,
  // Pixel input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        pixel_blue_i,
  input  logic [7:0]                        pixel_green_i,
  input  logic [7:0]                        pixel_red_i,
  input  logic                              first_of_frame_i,
  // Residual output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [7:0]                        residual_blue_o,
  output logic [7:0]                        residual_green_o,
  output logic [7:0]                        residual_red_o
);
  import ppr_pkg::*;

  localparam int unsigned AW  = (MAX_IMAGE_WIDTH > 1) ? $clog2(MAX_IMAGE_WIDTH) : 1;
  localparam int unsigned WW  = $clog2(MAX_IMAGE_WIDTH + 1);
  localparam int unsigned EW  = (WW > ImgWidthWidth) ? WW : ImgWidthWidth;

  // Configuration registers
  logic [ModeWidth-1:0]     mode_q;
  logic [ImgWidthWidth-1:0] width_q;
  logic                     cfg_wr;

  // Column tracking
  logic [AW-1:0] col_q, col_d, col_cur;
  logic          first_row_q, first_row_d, fr_cur;
  logic [EW-1:0] eff_w, img_ext, col_ext, col_inc;

  // Row store and stage one
  logic [23:0]   row_mem [MAX_IMAGE_WIDTH];
  logic [23:0]   rd_q;
  logic [23:0]   cur_pix;
  logic [23:0]   west_q;
  logic [23:0]   s1_cur_q, s1_west_q;
  logic          s1_colnz_q, s1_fr_q, s1_v_q;
  logic [23:0]   nw_q;
  logic [23:0]   north, west, nwest, resid;

  // Output register
  logic          out_v_q;
  logic [23:0]   out_q;

  logic          accept, out_ready, s1_adv;

  // Decode register writes
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeReset;
      width_q <= ImgWidthReset;
    end else if (cfg_wr) begin
      case (paddr[2])
        RegPredictorMode: mode_q  <= pwdata[ModeWidth-1:0];
        RegImageWidth:    width_q <= pwdata[ImgWidthWidth-1:0];
        default: ;
      endcase
    end
  end

  // Return register contents
  always_comb begin
    case (paddr[2])
      RegPredictorMode: prdata = {{(PprDataWidth-ModeWidth){1'b0}}, mode_q};
      RegImageWidth:    prdata = {{(PprDataWidth-ImgWidthWidth){1'b0}}, width_q};
      default:          prdata = '0;
    endcase
  end

  // Handshake: stage one frees when its word moves to the output register
  assign out_ready  = !out_v_q || !out_stall_i;
  assign s1_adv     = s1_v_q && out_ready;
  assign in_stall_o = s1_v_q && !out_ready;
  assign accept     = in_valid_i && !in_stall_o;

  // Clamp the row width to the store size, zero meaning one
  always_comb begin
    img_ext = EW'(width_q);
    if (width_q == '0) begin
      eff_w = EW'(1);
    end else if (img_ext > EW'(MAX_IMAGE_WIDTH)) begin
      eff_w = EW'(MAX_IMAGE_WIDTH);
    end else begin
      eff_w = img_ext;
    end
  end

  // Place the incoming pixel and advance the column
  always_comb begin
    col_ext = EW'(col_q);
    if (first_of_frame_i) begin
      col_cur = '0;
      fr_cur  = 1'b1;
    end else if (col_ext >= eff_w) begin
      col_cur = '0;
      fr_cur  = 1'b0;
    end else begin
      col_cur = col_q;
      fr_cur  = first_row_q;
    end
    col_inc = EW'(col_cur) + EW'(1);
    if (col_inc >= eff_w) begin
      col_d       = '0;
      first_row_d = 1'b0;
    end else begin
      col_d       = col_inc[AW-1:0];
      first_row_d = fr_cur;
    end
  end

  assign cur_pix = {pixel_red_i, pixel_green_i, pixel_blue_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      first_row_q <= 1'b1;
    end else if (accept) begin
      col_q       <= col_d;
      first_row_q <= first_row_d;
    end
  end

  // Read the row above and store the current pixel in its place
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q             <= row_mem[col_cur];
      row_mem[col_cur] <= cur_pix;
    end
  end

  // Capture the pixel and its west neighbor into stage one
  always_ff @(posedge clk_i) begin
    if (accept) begin
      west_q     <= cur_pix;
      s1_cur_q   <= cur_pix;
      s1_west_q  <= west_q;
      s1_colnz_q <= (col_cur != '0);
      s1_fr_q    <= fr_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (accept) begin
      s1_v_q <= 1'b1;
    end else if (s1_adv) begin
      s1_v_q <= 1'b0;
    end
  end

  // Mask neighbors that fall outside the image
  assign north = s1_fr_q ? 24'd0 : rd_q;
  assign west  = s1_colnz_q ? s1_west_q : 24'd0;
  assign nwest = (s1_colnz_q && !s1_fr_q) ? nw_q : 24'd0;

  // Predict and subtract per channel
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      resid[8*c +: 8] = s1_cur_q[8*c +: 8] -
                        ppr_predict(mode_q, west[8*c +: 8], north[8*c +: 8],
                                    nwest[8*c +: 8]);
    end
  end

  // Hold this word's north as the next word's northwest
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nw_q <= '0;
    end else if (s1_adv) begin
      nw_q <= north;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_ready) begin
      out_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= resid;
    end
  end

  assign out_valid_o      = out_v_q;
  assign residual_blue_o  = out_q[7:0];
  assign residual_green_o = out_q[15:8];
  assign residual_red_o   = out_q[23:16];

  // Input stalls only when both stages are full and the output is held
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_v_q && out_v_q && out_stall_i))
    else $error("input stalled without a full pipeline");

  // Column stays inside the row store
  a_col_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    EW'(col_q) < EW'(MAX_IMAGE_WIDTH))
    else $error("column beyond row store");

  // An accepted pixel occupies stage one on the next cycle
  a_accept_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_v_q)
    else $error("accepted pixel lost before stage one");

  // A word leaving stage one shows up at the output
  a_adv_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_v_q)
    else $error("stage one word dropped");

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// Pixel prediction residual testbench
// Streams BGR pixels through the block under every predictor and a range of
// row widths, predicts each residual word in a local tracker and compares
// it field by field with what the block returns.
// ----------------------------------------------------------------------------
module tb;
  import ppr_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned MaxPrinted = 20;
  localparam int unsigned MaxWidth   = PprMaxImageWidth;

  // Register byte addresses
  localparam logic [PprAddrWidth-1:0] AddrMode  = {RegPredictorMode, 2'b00};
  localparam logic [PprAddrWidth-1:0] AddrWidth = {RegImageWidth, 2'b00};

  typedef enum int unsigned {
    StallNone,
    StallLight,
    StallHeavy,
    StallPeriodic
  } stall_e;

  // Tracks the row store and position, predicts residual words
  class residual_tracker;
    logic [23:0]               row_store [MaxWidth];
    bit                        row_written [MaxWidth];
    logic [23:0]               west_px;
    logic [23:0]               nwest_px;
    int unsigned               col;
    bit                        first_row;
    logic [ModeWidth-1:0]      mode;
    logic [ImgWidthWidth-1:0]  width_reg;
    logic [23:0]               residual_q [$];
    int unsigned               errors;

    function new();
      foreach (row_written[i]) row_written[i] = 1'b0;
      west_px   = '0;
      nwest_px  = '0;
      col       = 0;
      first_row = 1'b1;
      mode      = ModeReset;
      width_reg = ImgWidthReset;
      errors    = 0;
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MaxWidth) return MaxWidth;
      return width_reg;
    endfunction

    function int unsigned pending();
      return residual_q.size();
    endfunction

    // True when a pixel without frame start would read a row entry never written
    function bit north_unwritten();
      int unsigned c;
      bit          fr;
      c  = col;
      fr = first_row;
      if (c >= eff_width()) begin
        c  = 0;
        fr = 1'b0;
      end
      return !fr && !row_written[c];
    endfunction

    function logic [7:0] predict_channel(int w, int n, int nw);
      int lo;
      int hi;
      int p;
      lo = (n < w) ? n : w;
      hi = (n < w) ? w : n;
      case (mode)
        ModeWest:      p = w;
        ModeNorth:     p = n;
        ModeNorthWest: p = nw;
        ModePlane:     p = n + w - nw;
        ModeNorthAdj:  p = n + (w - nw) / 2;
        ModeWestAdj:   p = w + (n - nw) / 2;
        ModeAverage:   p = (n + w) / 2;
        default: begin
          // Median edge detector
          if (nw >= hi) begin
            p = lo;
          end else if (nw <= lo) begin
            p = hi;
          end else begin
            p = n + w - nw;
          end
        end
      endcase
      return 8'(p);
    endfunction

    // Note an accepted pixel word and queue its residual word
    function void take_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic fof);
      int unsigned w;
      logic [23:0] cur;
      logic [23:0] north;
      logic [23:0] west;
      logic [23:0] nwest;
      logic [23:0] res;
      w = eff_width();
      if (fof) begin
        col       = 0;
        first_row = 1'b1;
      end else if (col >= w) begin
        col       = 0;
        first_row = 1'b0;
      end
      cur   = {r, g, b};
      north = first_row ? 24'h0 : row_store[col];
      west  = (col > 0) ? west_px : 24'h0;
      nwest = (col > 0 && !first_row) ? nwest_px : 24'h0;
      for (int i = 0; i < 3; i++) begin
        res[8*i +: 8] = cur[8*i +: 8] -
                        predict_channel(west[8*i +: 8], north[8*i +: 8], nwest[8*i +: 8]);
      end
      residual_q.insert(residual_q.size(), res);
      // Advance position
      nwest_px         = north;
      row_store[col]   = cur;
      row_written[col] = 1'b1;
      west_px          = cur;
      col++;
      if (col >= w) begin
        col       = 0;
        first_row = 1'b0;
      end
    endfunction

    task report(string what);
      if (errors < MaxPrinted) $display("tb: mismatch: %s", what);
      errors++;
    endtask

    // Compare one returned residual word with the oldest prediction
    task match_residual(logic [7:0] b, logic [7:0] g, logic [7:0] r);
      logic [23:0] want;
      if (residual_q.size() == 0) begin
        report($sformatf("residual %02h/%02h/%02h with none pending", b, g, r));
        return;
      end
      want = residual_q.pop_front();
      if (b !== want[7:0])
        report($sformatf("residual_blue %02h, predicted %02h", b, want[7:0]));
      if (g !== want[15:8])
        report($sformatf("residual_green %02h, predicted %02h", g, want[15:8]));
      if (r !== want[23:16])
        report($sformatf("residual_red %02h, predicted %02h", r, want[23:16]));
    endtask
  endclass

  logic                     clk_i;
  logic                     rst_ni           = 1'b0;
  logic                     psel             = 1'b0;
  logic                     penable          = 1'b0;
  logic                     pwrite           = 1'b0;
  logic [PprAddrWidth-1:0]  paddr            = '0;
  logic [PprDataWidth-1:0]  pwdata           = '0;
  logic [PprDataWidth-1:0]  prdata;
  logic                     pready;
  logic                     in_valid_i       = 1'b0;
  logic                     in_stall_o;
  logic [7:0]               pixel_blue_i     = '0;
  logic [7:0]               pixel_green_i    = '0;
  logic [7:0]               pixel_red_i      = '0;
  logic                     first_of_frame_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i      = 1'b0;
  logic [7:0]               residual_blue_o;
  logic [7:0]               residual_green_o;
  logic [7:0]               residual_red_o;

  int unsigned              cycle_count = 0;
  stall_e                   stall_style = StallNone;
  residual_tracker          tracker     = new();

  pixel_prediction_residual_top dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Count cycles, stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Stall the residual side on a pattern of its own
  always @(posedge clk_i) begin
    case (stall_style)
      StallNone:  out_stall_i <= 1'b0;
      StallLight: out_stall_i <= ($urandom_range(0, 3) == 0);
      StallHeavy: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:    out_stall_i <= (cycle_count % 11 < 4);
    endcase
  end

  // Check each accepted residual word
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.match_residual(residual_blue_o, residual_green_o, residual_red_o);
    end
  end

  task automatic reg_write(logic [PprAddrWidth-1:0] addr, int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= PprDataWidth'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    if (addr == AddrMode) tracker.mode = ModeWidth'(value);
    else tracker.width_reg = ImgWidthWidth'(value);
  endtask

  // Present one pixel word and hold it until accepted
  task automatic push_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic fof);
    if (!fof && tracker.north_unwritten()) fof = 1'b1;
    in_valid_i       <= 1'b1;
    pixel_blue_i     <= b;
    pixel_green_i    <= g;
    pixel_red_i      <= r;
    first_of_frame_i <= fof;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.take_pixel(b, g, r, fof);
  endtask

  task automatic idle(int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Drop valid and wait for every predicted word to come back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_level();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int unsigned widths [14];
    int unsigned count;
    int unsigned burst_left;
    bit          gapped;
    logic        fof;

    widths = '{3, 1, 2, 5, 16, 2047, 8, 1025, 2, 31, 4, 640, 7, 0};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings, stream starts without a frame marker
    stall_style <= StallLight;
    push_pixel(8'hff, 8'h00, 8'h80, 1'b0);
    push_pixel(8'h00, 8'hff, 8'h01, 1'b0);
    push_pixel(8'h80, 8'h80, 8'hff, 1'b0);
    drain();

    // Width zero behaves as one pixel per row
    reg_write(AddrWidth, 0);
    reg_write(AddrMode, ModeWest);
    push_pixel(8'h0a, 8'hc8, 8'hff, 1'b1);
    push_pixel(8'hff, 8'h00, 8'h00, 1'b0);
    push_pixel(8'h00, 8'hff, 8'h03, 1'b0);
    drain();

    // Plane predictor with wraparound on a two pixel wide frame
    reg_write(AddrWidth, 2);
    reg_write(AddrMode, ModePlane);
    push_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    push_pixel(8'hff, 8'hff, 8'hff, 1'b0);
    push_pixel(8'hff, 8'h00, 8'h80, 1'b0);
    push_pixel(8'h00, 8'hff, 8'h07, 1'b0);
    drain();

    // Median edges on both sides
    reg_write(AddrMode, ModeMedian);
    push_pixel(8'd200, 8'd10, 8'd100, 1'b1);
    push_pixel(8'd50, 8'd240, 8'd100, 1'b0);
    push_pixel(8'd100, 8'd100, 8'd100, 1'b0);
    push_pixel(8'd60, 8'd60, 8'd60, 1'b0);
    drain();

    // Negative half differences, frame continued
    reg_write(AddrMode, ModeNorthAdj);
    push_pixel(8'd1, 8'd254, 8'd100, 1'b0);
    push_pixel(8'd200, 8'd3, 8'd50, 1'b0);
    push_pixel(8'd0, 8'd255, 8'd1, 1'b0);
    push_pixel(8'd255, 8'd0, 8'd254, 1'b0);
    drain();

    // Random phases over every mode and a spread of widths
    for (int p = 0; p < 14; p++) begin
      reg_write(AddrMode, (p * 3) % 8);
      reg_write(AddrWidth, widths[p]);
      stall_style <= stall_e'(p % 4);
      gapped     = (p % 3 != 0);
      count      = (widths[p] >= 64) ? 150 : 80;
      burst_left = $urandom_range(1, 40);
      for (int k = 0; k < count; k++) begin
        fof = (k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 99) == 0);
        push_pixel(rand_level(), rand_level(), rand_level(), fof);
        if (burst_left == 0) begin
          if (gapped) idle($urandom_range(1, 6));
          burst_left = $urandom_range(1, 40);
        end else begin
          burst_left--;
        end
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (tracker.pending() != 0) tracker.report("residual words still pending at end");
    if (tracker.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- pixel_prediction_residual_top.f -----
rtl/core/ppr_pkg.sv
rtl/core/pixel_prediction_residual_top.sv
tb/sv/tb.sv
